>>> src/scrbg_pkg.sv
package scrbg_pkg;

   localparam int BUFFER_BYTES = 64;
   localparam int BUF_AW = $clog2(BUFFER_BYTES);
   localparam int SURF_WORDS = 8;
   localparam int SURF_BYTES = 4 * SURF_WORDS;
   localparam int SURF_BW = $clog2(SURF_BYTES);
   localparam int STATE_WORDS = 12;
   localparam int ROUNDS = 16;
   localparam int MAX_REQUEST_DEFAULT = 64;
   localparam int COUNT_W = 7;

   localparam logic [31:0] GOLDEN = 32'h9e3779b9;

   localparam logic [31:0] SEED_TABLE [32] = '{
      32'd3, 32'd1, 32'd4, 32'd1, 32'd5, 32'd9, 32'd2, 32'd6,
      32'd5, 32'd3, 32'd5, 32'd8, 32'd9, 32'd7, 32'd9, 32'd3,
      32'd2, 32'd3, 32'd8, 32'd4, 32'd6, 32'd2, 32'd6, 32'd4,
      32'd3, 32'd3, 32'd8, 32'd3, 32'd2, 32'd7, 32'd9, 32'd5
   };

   localparam logic [4:0] ROT_TABLE [4] = '{5'd5, 5'd7, 5'd9, 5'd13};

   typedef logic [3:0][31:0] counter_type;
   typedef logic [SURF_WORDS-1:0][31:0] surf_words_type;

   typedef struct packed {
      logic start;
   } surf_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } surf_status_type;

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] amt);
      logic [5:0] back;
      back = 6'd32 - {1'b0, amt};
      return (v << amt) | (v >> back);
   endfunction

endpackage

>>> src/scrbg_surf_core.sv
module scrbg_surf_core (
   input  logic                       clock,
   input  logic                       reset,
   input  scrbg_pkg::surf_ctrl_type   ctrl,
   input  scrbg_pkg::counter_type     counter,
   output scrbg_pkg::surf_status_type status,
   output scrbg_pkg::surf_words_type  result
);

   typedef enum logic [2:0] {
      C_IDLE = 3'b001,
      C_RUN  = 3'b010,
      C_FOLD = 3'b100
   } core_state_type;

   core_state_type state_ff, state_in;

   logic [31:0] t_ff [scrbg_pkg::STATE_WORDS];
   logic [31:0] x_ff;
   logic [31:0] sum_ff;
   logic [3:0]  step_ff;
   logic [3:0]  round_ff;
   logic        pass_ff;
   logic        done_ff, done_in;
   scrbg_pkg::surf_words_type res_ff;

   logic [31:0] mix;
   logic [31:0] t_new;
   logic        last_step;

   // one word update of the round
   always_comb begin
      mix = ((x_ff ^ scrbg_pkg::SEED_TABLE[5'(step_ff)]) + sum_ff)
            ^ scrbg_pkg::rotl32(x_ff, scrbg_pkg::ROT_TABLE[step_ff[1:0]]);
      t_new = t_ff[0] + mix;
      last_step = (step_ff == 4'(scrbg_pkg::STATE_WORDS - 1))
                  && (round_ff == 4'(scrbg_pkg::ROUNDS - 1));
   end

   always_comb begin
      state_in = state_ff;
      done_in = 1'b0;
      case (state_ff)
         C_IDLE: begin
            if (ctrl.start) state_in = C_RUN;
         end
         C_RUN: begin
            if (last_step) state_in = C_FOLD;
         end
         C_FOLD: begin
            if (pass_ff) begin
               state_in = C_IDLE;
               done_in = 1'b1;
            end else begin
               state_in = C_RUN;
            end
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         C_IDLE: begin
            if (ctrl.start) begin
               for (int k = 0; k < scrbg_pkg::STATE_WORDS; k++) begin
                  t_ff[k] <= ((k < 4) ? counter[k[1:0]] : 32'd0)
                             ^ scrbg_pkg::SEED_TABLE[12 + k];
               end
               for (int k = 0; k < scrbg_pkg::SURF_WORDS; k++) begin
                  res_ff[k] <= scrbg_pkg::SEED_TABLE[24 + k];
               end
               x_ff <= scrbg_pkg::SEED_TABLE[23];
               sum_ff <= scrbg_pkg::GOLDEN;
               step_ff <= 4'd0;
               round_ff <= 4'd0;
               pass_ff <= 1'b0;
            end
         end
         C_RUN: begin
            // rotate so the word being updated is always at the head
            for (int k = 0; k < scrbg_pkg::STATE_WORDS - 1; k++) begin
               t_ff[k] <= t_ff[k + 1];
            end
            t_ff[scrbg_pkg::STATE_WORDS - 1] <= t_new;
            x_ff <= t_new;
            if (step_ff == 4'(scrbg_pkg::STATE_WORDS - 1)) begin
               step_ff <= 4'd0;
               sum_ff <= sum_ff + scrbg_pkg::GOLDEN;
               round_ff <= round_ff + 4'd1;
            end else begin
               step_ff <= step_ff + 4'd1;
            end
         end
         C_FOLD: begin
            for (int k = 0; k < scrbg_pkg::SURF_WORDS; k++) begin
               res_ff[k] <= res_ff[k] ^ t_ff[k + 4];
            end
            pass_ff <= 1'b1;
         end
         default: ;
      endcase
   end

   assign status.busy = (state_ff != C_IDLE);
   assign status.done = done_ff;
   assign result = res_ff;

endmodule

>>> src/surf_counter_random_byte_generator_unit.sv
// Deterministic random byte source on the SURF function with a fixed seed table.
// Each req item asks for 1 to 64 bytes (0 gives no result, above the maximum is
// clipped) and the block returns one rsp item per byte, last set on the final
// one; req_ready is low until that last byte is taken. A byte taken from the
// 64-byte buffer is read in S_NEXT and held in S_OUT through any rsp stall. When
// the buffer runs empty it is refilled from two SURF evaluations on the bumped
// 128-bit counter: the single shared round unit does one 32-bit word update per
// cycle (384 per evaluation) and the buffer memory takes one byte write per cycle
// (32 per evaluation).
module surf_counter_random_byte_generator_unit #(
   parameter int MAX_REQUEST = scrbg_pkg::MAX_REQUEST_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [6:0] req_byte_count,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_rand_byte,
   output logic       rsp_last
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_NEXT  = 6'b000010,
      S_START = 6'b000100,
      S_WAIT  = 6'b001000,
      S_STORE = 6'b010000,
      S_OUT   = 6'b100000
   } top_state_type;

   localparam int CW = scrbg_pkg::COUNT_W;
   localparam int AW = scrbg_pkg::BUF_AW;
   localparam int JW = scrbg_pkg::SURF_BW;

   top_state_type state_ff, state_in;
   scrbg_pkg::counter_type ctr_ff, ctr_in;
   logic [CW-1:0] bytes_left_ff, bytes_left_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic          half_ff, half_in;
   logic [JW-1:0] wr_idx_ff, wr_idx_in;

   logic [7:0] buf_mem [scrbg_pkg::BUFFER_BYTES];
   logic [7:0] rd_ff;

   logic [CW-1:0] req_n;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;

   scrbg_pkg::surf_ctrl_type   core_ctrl;
   scrbg_pkg::surf_status_type core_status;
   scrbg_pkg::surf_words_type  core_result;

   scrbg_surf_core u_core (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (core_ctrl),
      .counter (ctr_ff),
      .status  (core_status),
      .result  (core_result)
   );

   assign req_n = (req_byte_count > CW'(MAX_REQUEST)) ? CW'(MAX_REQUEST) : req_byte_count;
   assign rd_addr = AW'(bytes_left_ff - CW'(1));
   assign wr_addr = {half_ff, wr_idx_ff};
   assign wr_data = core_result[wr_idx_ff[JW-1:2]][8*wr_idx_ff[1:0] +: 8];

   always_comb begin
      state_in = state_ff;
      ctr_in = ctr_ff;
      bytes_left_in = bytes_left_ff;
      remain_in = remain_ff;
      half_in = half_ff;
      wr_idx_in = wr_idx_ff;
      rd_en = 1'b0;
      wr_en = 1'b0;
      core_ctrl.start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && (req_n != '0)) begin
               remain_in = req_n;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (bytes_left_ff == '0) begin
               ctr_in = ctr_ff + 128'd1;
               half_in = 1'b0;
               state_in = S_START;
            end else begin
               rd_en = 1'b1;
               bytes_left_in = bytes_left_ff - CW'(1);
               state_in = S_OUT;
            end
         end
         S_START: begin
            core_ctrl.start = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (core_status.done) begin
               wr_idx_in = '0;
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            wr_en = 1'b1;
            wr_idx_in = wr_idx_ff + JW'(1);
            if (wr_idx_ff == JW'(scrbg_pkg::SURF_BYTES - 1)) begin
               if (!half_ff) begin
                  half_in = 1'b1;
                  ctr_in = ctr_ff + 128'd1;
                  state_in = S_START;
               end else begin
                  bytes_left_in = CW'(scrbg_pkg::BUFFER_BYTES);
                  state_in = S_NEXT;
               end
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               remain_in = remain_ff - CW'(1);
               state_in = (remain_ff == CW'(1)) ? S_IDLE : S_NEXT;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ctr_ff <= '0;
         bytes_left_ff <= '0;
         remain_ff <= '0;
         half_ff <= 1'b0;
         wr_idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         ctr_ff <= ctr_in;
         bytes_left_ff <= bytes_left_in;
         remain_ff <= remain_in;
         half_ff <= half_in;
         wr_idx_ff <= wr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) buf_mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= buf_mem[rd_addr];
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_rand_byte = rd_ff;
   assign rsp_last = (remain_ff == CW'(1));

endmodule

>>> src/scrbg_checker.sv
module scrbg_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [6:0] req_byte_count,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_rand_byte,
   input logic       rsp_last
);

   // one item at a time: never open for a new item while a byte is offered
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready && rsp_valid))
      else $error("req accepted while rsp pending");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_byte_count != 7'd0)) |=> !req_ready)
      else $error("ready right after a nonzero item");

   a_gap_after_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid)
      else $error("rsp valid right after a taken byte");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_rand_byte) && $stable(rsp_last)))
      else $error("stalled rsp changed");

endmodule

bind surf_counter_random_byte_generator_unit scrbg_checker u_scrbg_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_byte_count (req_byte_count),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_rand_byte  (rsp_rand_byte),
   .rsp_last       (rsp_last)
);
